### rtl/best_fit_heap_allocator_assert.svh
// Assertion macros for the best-fit heap allocator.
// BFHA_ASSERT is disabled while reset is asserted; BFHA_ASSERT_ALWAYS is
// checked at every clock edge, including during reset.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BFHA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFHA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFHA_ASSERT(name, prop, msg)
`define BFHA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### rtl/bfha_pkg.sv
`default_nettype none

package bfha_pkg;

    // Heap geometry. The header store holds one entry per 16-byte unit.
    localparam int HEAP_BYTES = 16384;
    localparam int UNITS      = HEAP_BYTES / 16;
    localparam int UNIT_W     = $clog2(UNITS);

    // Fixed field widths of the request and response.
    localparam int REQ_W = 14;
    localparam int OFF_W = 14;

    // Block size needed for a request, in units: (bytes + 8 + 15) / 16.
    localparam int NEED_W = REQ_W + 1 - 4;
    localparam logic [REQ_W:0] NEED_BIAS = (REQ_W + 1)'(8 + 15);

    // Common width for size compares, and one more bit for unit positions
    // that may run past the end of the store.
    localparam int CMP_W = (UNIT_W > NEED_W) ? UNIT_W : NEED_W;
    localparam int NXT_W = CMP_W + 1;

    // One block header. The size is kept in 16-byte units; zero is the end mark.
    typedef struct packed {
        logic [UNIT_W-1:0] units;
        logic              prev_busy;
        logic              busy;
    } header_t;

endpackage

`default_nettype wire

### rtl/best_fit_heap_allocator.sv
`default_nettype none
// Channel   | Handshake              | Payload                    | Direction
// ----------+------------------------+----------------------------+----------
// request   | in_valid / in_ready    | request_bytes[13:0]        | in
// response  | out_valid / out_ready  | granted, payload_offset    | out
//
// Sequence: a request is accepted in S_IDLE, then the walk visits each block
// header in turn (one read of the header memory each); for a grant, the chosen
// header and the header after it are written, and the response register is loaded last.
// A zero request goes straight to the response load. Only one request is in the block at a time.
// Reset: after rst_n is released the block writes the first header and then the
// end mark, with in_ready low; no other entry needs clearing.
// Stalls: the response register holds a finished transaction while out_ready
// is low; a new request is still accepted and walked, and only its response
// load waits for the register to drain.

`include "best_fit_heap_allocator_assert.svh"

module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REQ_W-1:0] request_bytes,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  granted,
    output logic [OFF_W-1:0]      payload_offset
);

    // The sequencer walks the implicit block list. The walk issues the read of
    // the next header in the same cycle that it evaluates the current one, so
    // the memory's registered read port adds no wait per header.
    typedef enum logic [2:0] {
        S_INIT_HEAD,
        S_INIT_TAIL,
        S_IDLE,
        S_WALK,
        S_SPLIT,
        S_MARK,
        S_PREV,
        S_RESULT
    } state_t;

    // Header memory: one write port and one registered read port.
    header_t mem [UNITS];
    header_t rdata_reg;

    logic              wr_en;
    logic [UNIT_W-1:0] wr_addr;
    header_t           wr_data;
    logic [UNIT_W-1:0] rd_addr;

    state_t            state_reg,      state_next;
    logic [UNIT_W-1:0] u_reg,          u_next;
    logic [NEED_W-1:0] need_reg,       need_next;
    logic              found_reg,      found_next;
    logic [UNIT_W-1:0] best_reg,       best_next;
    logic [UNIT_W-1:0] best_units_reg, best_units_next;
    logic              best_prev_reg,  best_prev_next;
    logic [NXT_W-1:0]  nxt_reg,        nxt_next;
    logic              split_reg,      split_next;
    logic [UNIT_W-1:0] rest_reg,       rest_next;
    logic              grant_reg,      grant_next;
    logic              out_valid_reg,  out_valid_next;
    logic              granted_reg,    granted_next;
    logic [OFF_W-1:0]  offset_reg,     offset_next;

    // Walk evaluation of the header that arrives this cycle.
    logic              hdr_end;
    logic              hdr_fits;
    logic              hdr_take;
    logic [NXT_W-1:0]  next_u;
    logic              walk_stop;
    logic              f_found;
    logic [UNIT_W-1:0] f_best;
    logic [UNIT_W-1:0] f_units;
    logic              f_prev;
    logic [CMP_W-1:0]  f_rest;
    logic              nxt_in_store;
    logic [NEED_W-1:0] req_need;

    assign req_need = NEED_W'((((REQ_W + 1)'(request_bytes)) + NEED_BIAS) >> 4);

    assign hdr_end  = (rdata_reg.units == '0);
    assign hdr_fits = !rdata_reg.busy &&
                      (CMP_W'(rdata_reg.units) >= CMP_W'(need_reg));
    // Strictly smaller replaces, so the first of equal sizes wins.
    assign hdr_take = hdr_fits && (!found_reg || (rdata_reg.units < best_units_reg));

    assign next_u    = NXT_W'(u_reg) + NXT_W'(rdata_reg.units);
    assign walk_stop = hdr_end || (next_u >= NXT_W'(UNITS - 1));

    assign f_found = found_reg || hdr_take;
    assign f_best  = hdr_take ? u_reg : best_reg;
    assign f_units = hdr_take ? rdata_reg.units : best_units_reg;
    assign f_prev  = hdr_take ? rdata_reg.prev_busy : best_prev_reg;
    assign f_rest  = CMP_W'(f_units) - CMP_W'(need_reg);

    assign nxt_in_store = (nxt_reg < NXT_W'(UNITS));

    always_comb
    begin
        state_next      = state_reg;
        u_next          = u_reg;
        need_next       = need_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_units_next = best_units_reg;
        best_prev_next  = best_prev_reg;
        nxt_next        = nxt_reg;
        split_next      = split_reg;
        rest_next       = rest_reg;
        grant_next      = grant_reg;
        granted_next    = granted_reg;
        offset_next     = offset_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = u_reg;

        unique case (state_reg)
            S_INIT_HEAD:
            begin
                // The first block spans the whole heap but the end-mark unit.
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{units: UNIT_W'(UNITS - 1), prev_busy: 1'b1, busy: 1'b0};
                state_next = S_INIT_TAIL;
            end
            S_INIT_TAIL:
            begin
                wr_en      = 1'b1;
                wr_addr    = UNIT_W'(UNITS - 1);
                wr_data    = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_valid)
                begin
                    need_next  = req_need;
                    u_next     = '0;
                    found_next = 1'b0;
                    grant_next = 1'b0;
                    if (request_bytes == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                found_next      = f_found;
                best_next       = f_best;
                best_units_next = f_units;
                best_prev_next  = f_prev;
                if (walk_stop)
                begin
                    grant_next = f_found;
                    split_next = (f_rest != '0);
                    rest_next  = UNIT_W'(f_rest);
                    if (f_rest != '0)
                    begin
                        nxt_next = NXT_W'(f_best) + NXT_W'(need_reg);
                    end
                    else
                    begin
                        nxt_next = NXT_W'(f_best) + NXT_W'(f_units);
                    end
                    if (!f_found)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (f_rest != '0)
                    begin
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
                else
                begin
                    u_next  = UNIT_W'(next_u);
                    rd_addr = UNIT_W'(next_u);
                end
            end
            S_SPLIT:
            begin
                // The leftover becomes a new free block after a busy neighbor.
                wr_en      = nxt_in_store;
                wr_addr    = UNIT_W'(nxt_reg);
                wr_data    = '{units: rest_reg, prev_busy: 1'b1, busy: 1'b0};
                state_next = S_MARK;
            end
            S_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = best_reg;
                wr_data = '{units: split_reg ? UNIT_W'(need_reg) : best_units_reg,
                            prev_busy: best_prev_reg, busy: 1'b1};
                // For a whole-block grant, fetch the following header to set
                // its prev-busy bit; it never aliases the entry written here.
                rd_addr = UNIT_W'(nxt_reg);
                if (split_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                wr_en             = nxt_in_store;
                wr_addr           = UNIT_W'(nxt_reg);
                wr_data           = rdata_reg;
                wr_data.prev_busy = 1'b1;
                state_next        = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = grant_reg;
                    offset_next    = grant_reg ? OFF_W'({best_reg, 4'b1000}) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT_HEAD;
            u_reg          <= '0;
            need_reg       <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_units_reg <= '0;
            best_prev_reg  <= 1'b0;
            nxt_reg        <= '0;
            split_reg      <= 1'b0;
            rest_reg       <= '0;
            grant_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            granted_reg    <= 1'b0;
            offset_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            u_reg          <= u_next;
            need_reg       <= need_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
            best_units_reg <= best_units_next;
            best_prev_reg  <= best_prev_next;
            nxt_reg        <= nxt_next;
            split_reg      <= split_next;
            rest_reg       <= rest_next;
            grant_reg      <= grant_next;
            out_valid_reg  <= out_valid_next;
            granted_reg    <= granted_next;
            offset_reg     <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign payload_offset = offset_reg;

    // The header store is only written while a request is being committed
    // or during the start-up writes, never while waiting for a request.
    `BFHA_ASSERT(a_no_write_idle, (state_reg == S_IDLE) |-> !wr_en, "header write while idle")
    // The walk never visits the end-mark unit or beyond.
    `BFHA_ASSERT(a_walk_in_range, (state_reg == S_WALK) |-> (u_reg < UNIT_W'(UNITS - 1)), "walk out of range")
    // Headers are committed only for a block that was actually chosen.
    `BFHA_ASSERT(a_mark_found, (state_reg == S_MARK) |-> (found_reg && grant_reg), "commit without a fit")
    // No request is taken in the cycle after reset was asserted.
    `BFHA_ASSERT_ALWAYS(a_reset_blocks, !rst_n |=> !in_ready, "request accepted during start-up")

endmodule

`default_nettype wire
